FILE: rtl/tds_pkg.sv
`default_nettype none
package tds_pkg;

    localparam int MAX_ROWS = 64;
    localparam int IDX_W    = $clog2(MAX_ROWS);
    localparam int CNT_W    = $clog2(MAX_ROWS + 2);
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int DVD_W    = DATA_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DVD_W);
    localparam int ROWA_W   = 3 * DATA_W;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_ZERO_PIVOT   = 2'd1;
    localparam logic [1:0] ST_MISMATCH     = 2'd2;
    localparam logic [1:0] ST_NOT_FACTORED = 2'd3;

    localparam logic KIND_STATUS   = 1'b0;
    localparam logic KIND_SOLUTION = 1'b1;

    localparam logic OP_ROW = 1'b0;
    localparam logic OP_RHS = 1'b1;

    localparam logic [2:0] ADDR_PIVOT_THRESHOLD = 3'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW_RD,
        S_ROW_MUL,
        S_ROW_SUB,
        S_ROW_DIV,
        S_ROW_WR,
        S_RHS_RD,
        S_RHS_MUL,
        S_RHS_SUB,
        S_RHS_DIV,
        S_RHS_WR,
        S_BS_RD,
        S_BS_MUL,
        S_BS_SUB,
        S_BS_OUT,
        S_STATUS
    } state_t;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] num;
        logic signed [DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quo;
    } div_rsp_t;

    // Q16.16 product: drop 16 fraction bits toward zero, then saturate.
    function automatic logic signed [DATA_W-1:0] qmul_fix(input logic signed [63:0] p);
        logic signed [63:0] t;
        begin
            if (p < 0) begin
                t = (p + 64'sd65535) >>> FRAC_W;
            end else begin
                t = p >>> FRAC_W;
            end
            if (t > 64'sd2147483647) begin
                qmul_fix = 32'sh7FFFFFFF;
            end else if (t < -64'sd2147483648) begin
                qmul_fix = 32'sh80000000;
            end else begin
                qmul_fix = t[DATA_W-1:0];
            end
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] sub_sat(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] t;
        begin
            t = {a[DATA_W-1], a} - {b[DATA_W-1], b};
            if (t[DATA_W] != t[DATA_W-1]) begin
                sub_sat = t[DATA_W] ? 32'sh80000000 : 32'sh7FFFFFFF;
            end else begin
                sub_sat = t[DATA_W-1:0];
            end
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/tridiagonal_system_solver.sv
`default_nettype none
// Channel    Handshake          Word
// s_ (in)    s_valid/s_ready    opcode, lower/diag/upper coef, rhs value, last flag
// m_ (out)   m_valid/m_ready    result kind, row index, solution value, status, last flag
// APB        psel/penable       pivot_threshold at byte address 0
//
// A matrix row goes through read, multiply, subtract, the 48-step quotient loop
// of the divider (skipped for the last row) and write. A right-hand-side element
// runs the same steps. Back substitution reads, multiplies, subtracts and emits
// each solution word. Reset is synchronous; the stores need no clearing pass. A
// stalled m_ready holds the block in its emit state; s_ready is high only when idle.
module tridiagonal_system_solver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_opcode,
    input  wire logic [31:0] s_lower_coef,
    input  wire logic [31:0] s_diag_coef,
    input  wire logic [31:0] s_upper_coef,
    input  wire logic [31:0] s_rhs_value,
    input  wire logic        s_last_item,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_result_kind,
    output logic [5:0]       m_row_index,
    output logic [31:0]      m_solution_value,
    output logic [1:0]       m_status_code,
    output logic             m_last_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IW = tds_pkg::IDX_W;
    localparam int CW = tds_pkg::CNT_W;
    localparam int DW = tds_pkg::DATA_W;

    tds_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   rc_reg, rc_next;
    logic [CW-1:0]   rhs_reg, rhs_next;
    logic            fv_reg, fv_next;
    logic            fault_reg, fault_next;
    logic [30:0]     thr_reg;
    logic            ov_reg, ov_next;
    logic            okind_reg, okind_next;
    logic [IW-1:0]   oidx_reg, oidx_next;
    logic [DW-1:0]   oval_reg, oval_next;
    logic [1:0]      ost_reg, ost_next;
    logic            olast_reg, olast_next;

    logic signed [DW-1:0] lo_reg, lo_next;
    logic signed [DW-1:0] dg_reg, dg_next;
    logic signed [DW-1:0] up_reg, up_next;
    logic                 last_reg, last_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [IW-1:0]        addr_a_reg, addr_a_next;
    logic [IW-1:0]        addr_b_reg, addr_b_next;
    logic signed [DW-1:0] val_reg, val_next;
    logic signed [DW-1:0] su_reg, su_next;
    logic signed [DW-1:0] piv_reg, piv_next;
    logic signed [DW-1:0] xprev_reg, xprev_next;
    logic                 first_reg, first_next;
    logic [1:0]           st_reg, st_next;
    logic signed [63:0]   prod_reg;

    logic [tds_pkg::ROWA_W-1:0] rd_a;
    logic [DW-1:0]              rd_b;
    logic                       we_a, we_b;
    logic [DW-1:0]              wd_b;
    logic signed [DW-1:0]       mul_a, mul_b;
    logic signed [DW-1:0]       d_new, r_new, x_new;
    logic [DW-1:0]              d_mag;
    logic                       out_free;
    logic                       new_matrix;
    logic [CW-1:0]              rc_eff;
    tds_pkg::div_req_t          dreq;
    tds_pkg::div_rsp_t          drsp;

    tds_ram #(.WIDTH(tds_pkg::ROWA_W), .DEPTH(tds_pkg::MAX_ROWS)) u_row_ram (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (idx_reg),
        .wdata ({val_reg, su_reg, lo_reg}),
        .raddr (addr_a_reg),
        .rdata (rd_a)
    );

    tds_ram #(.WIDTH(DW), .DEPTH(tds_pkg::MAX_ROWS)) u_sol_ram (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (idx_reg),
        .wdata (wd_b),
        .raddr (addr_b_reg),
        .rdata (rd_b)
    );

    tds_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign pready  = 1'b1;
    assign prdata  = (paddr == tds_pkg::ADDR_PIVOT_THRESHOLD) ? {1'b0, thr_reg} : '0;
    assign s_ready = (state_reg == tds_pkg::S_IDLE);
    assign out_free = !ov_reg || m_ready;

    assign m_valid          = ov_reg;
    assign m_result_kind    = okind_reg;
    assign m_row_index      = oidx_reg;
    assign m_solution_value = oval_reg;
    assign m_status_code    = ost_reg;
    assign m_last_result    = olast_reg;

    // row layout: pivot [95:64], scaled upper [63:32], lower [31:0]
    always_comb begin
        case (state_reg)
            tds_pkg::S_ROW_MUL: begin
                mul_a = lo_reg;
                mul_b = (idx_reg == '0) ? '0 : rd_a[63:32];
            end
            tds_pkg::S_RHS_MUL: begin
                mul_a = rd_a[31:0];
                mul_b = (idx_reg == '0) ? '0 : rd_b;
            end
            tds_pkg::S_BS_MUL: begin
                mul_a = rd_a[63:32];
                mul_b = first_reg ? '0 : xprev_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign d_new = tds_pkg::sub_sat(dg_reg, tds_pkg::qmul_fix(prod_reg));
    assign r_new = tds_pkg::sub_sat(val_reg, tds_pkg::qmul_fix(prod_reg));
    assign x_new = r_new;
    assign d_mag = d_new[DW-1] ? (~d_new + 32'd1) : d_new;

    assign dreq.start = ((state_reg == tds_pkg::S_ROW_SUB) && !last_reg)
                        || (state_reg == tds_pkg::S_RHS_SUB);
    assign dreq.num   = (state_reg == tds_pkg::S_ROW_SUB) ? up_reg : r_new;
    assign dreq.den   = (state_reg == tds_pkg::S_ROW_SUB) ? d_new : piv_reg;

    assign new_matrix = fv_reg || (rc_reg == '0);
    assign rc_eff     = new_matrix ? '0 : rc_reg;

    assign we_a = (state_reg == tds_pkg::S_ROW_WR);
    assign we_b = (state_reg == tds_pkg::S_RHS_WR) || (state_reg == tds_pkg::S_BS_SUB);
    assign wd_b = (state_reg == tds_pkg::S_BS_SUB) ? x_new : val_reg;

    always_comb begin
        state_next  = state_reg;
        rc_next     = rc_reg;
        rhs_next    = rhs_reg;
        fv_next     = fv_reg;
        fault_next  = fault_reg;
        ov_next     = m_ready ? 1'b0 : ov_reg;
        okind_next  = okind_reg;
        oidx_next   = oidx_reg;
        oval_next   = oval_reg;
        ost_next    = ost_reg;
        olast_next  = olast_reg;
        lo_next     = lo_reg;
        dg_next     = dg_reg;
        up_next     = up_reg;
        last_next   = last_reg;
        idx_next    = idx_reg;
        addr_a_next = addr_a_reg;
        addr_b_next = addr_b_reg;
        val_next    = val_reg;
        su_next     = su_reg;
        piv_next    = piv_reg;
        xprev_next  = xprev_reg;
        first_next  = first_reg;
        st_next     = st_reg;

        case (state_reg)
            tds_pkg::S_IDLE: begin
                if (s_valid) begin
                    last_next = s_last_item;
                    if (s_opcode == tds_pkg::OP_ROW) begin
                        if (new_matrix) begin
                            fv_next    = 1'b0;
                            fault_next = 1'b0;
                            rhs_next   = '0;
                            rc_next    = '0;
                        end
                        if (rc_eff < CW'(tds_pkg::MAX_ROWS)) begin
                            idx_next    = rc_eff[IW-1:0];
                            addr_a_next = rc_eff[IW-1:0] - 1'b1;
                            lo_next     = (rc_eff == '0) ? '0 : s_lower_coef;
                            dg_next     = s_diag_coef;
                            up_next     = s_upper_coef;
                            state_next  = tds_pkg::S_ROW_RD;
                        end else begin
                            rc_next = CW'(tds_pkg::MAX_ROWS + 1);
                            if (s_last_item) begin
                                rc_next    = '0;
                                st_next    = tds_pkg::ST_MISMATCH;
                                state_next = tds_pkg::S_STATUS;
                            end
                        end
                    end else begin
                        if (!fv_reg) begin
                            if (s_last_item) begin
                                rhs_next   = '0;
                                st_next    = tds_pkg::ST_NOT_FACTORED;
                                state_next = tds_pkg::S_STATUS;
                            end
                        end else if (rhs_reg < rc_reg) begin
                            idx_next    = rhs_reg[IW-1:0];
                            addr_a_next = rhs_reg[IW-1:0];
                            addr_b_next = rhs_reg[IW-1:0] - 1'b1;
                            val_next    = s_rhs_value;
                            state_next  = tds_pkg::S_RHS_RD;
                        end else begin
                            rhs_next = rc_reg + 1'b1;
                            if (s_last_item) begin
                                rhs_next   = '0;
                                st_next    = tds_pkg::ST_MISMATCH;
                                state_next = tds_pkg::S_STATUS;
                            end
                        end
                    end
                end
            end
            tds_pkg::S_ROW_RD: state_next = tds_pkg::S_ROW_MUL;
            tds_pkg::S_ROW_MUL: state_next = tds_pkg::S_ROW_SUB;
            tds_pkg::S_ROW_SUB: begin
                val_next = d_new;
                if (d_mag <= {1'b0, thr_reg}) begin
                    fault_next = 1'b1;
                end
                if (last_reg) begin
                    su_next    = '0;
                    state_next = tds_pkg::S_ROW_WR;
                end else begin
                    state_next = tds_pkg::S_ROW_DIV;
                end
            end
            tds_pkg::S_ROW_DIV: begin
                if (drsp.done) begin
                    su_next    = drsp.quo;
                    state_next = tds_pkg::S_ROW_WR;
                end
            end
            tds_pkg::S_ROW_WR: begin
                rc_next    = {1'b0, idx_reg} + 1'b1;
                state_next = tds_pkg::S_IDLE;
                if (last_reg) begin
                    state_next = tds_pkg::S_STATUS;
                    if (fault_reg) begin
                        rc_next = '0;
                        st_next = tds_pkg::ST_ZERO_PIVOT;
                    end else begin
                        fv_next = 1'b1;
                        st_next = tds_pkg::ST_OK;
                    end
                end
            end
            tds_pkg::S_RHS_RD: state_next = tds_pkg::S_RHS_MUL;
            tds_pkg::S_RHS_MUL: begin
                piv_next   = rd_a[95:64];
                state_next = tds_pkg::S_RHS_SUB;
            end
            tds_pkg::S_RHS_SUB: state_next = tds_pkg::S_RHS_DIV;
            tds_pkg::S_RHS_DIV: begin
                if (drsp.done) begin
                    val_next   = drsp.quo;
                    state_next = tds_pkg::S_RHS_WR;
                end
            end
            tds_pkg::S_RHS_WR: begin
                rhs_next   = {1'b0, idx_reg} + 1'b1;
                state_next = tds_pkg::S_IDLE;
                if (last_reg) begin
                    rhs_next = '0;
                    if (({1'b0, idx_reg} + 1'b1) != rc_reg) begin
                        st_next    = tds_pkg::ST_MISMATCH;
                        state_next = tds_pkg::S_STATUS;
                    end else begin
                        // start back substitution from the last row
                        idx_next    = idx_reg;
                        addr_a_next = idx_reg;
                        addr_b_next = idx_reg;
                        first_next  = 1'b1;
                        state_next  = tds_pkg::S_BS_RD;
                    end
                end
            end
            tds_pkg::S_BS_RD: state_next = tds_pkg::S_BS_MUL;
            tds_pkg::S_BS_MUL: begin
                val_next   = rd_b;
                state_next = tds_pkg::S_BS_SUB;
            end
            tds_pkg::S_BS_SUB: begin
                xprev_next = x_new;
                state_next = tds_pkg::S_BS_OUT;
            end
            tds_pkg::S_BS_OUT: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    okind_next = tds_pkg::KIND_SOLUTION;
                    oidx_next  = idx_reg;
                    oval_next  = xprev_reg;
                    ost_next   = tds_pkg::ST_OK;
                    olast_next = (idx_reg == '0);
                    if (idx_reg == '0) begin
                        state_next = tds_pkg::S_IDLE;
                    end else begin
                        idx_next    = idx_reg - 1'b1;
                        addr_a_next = idx_reg - 1'b1;
                        addr_b_next = idx_reg - 1'b1;
                        first_next  = 1'b0;
                        state_next  = tds_pkg::S_BS_RD;
                    end
                end
            end
            tds_pkg::S_STATUS: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    okind_next = tds_pkg::KIND_STATUS;
                    oidx_next  = '0;
                    oval_next  = '0;
                    ost_next   = st_reg;
                    olast_next = 1'b1;
                    state_next = tds_pkg::S_IDLE;
                end
            end
            default: state_next = tds_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tds_pkg::S_IDLE;
            rc_reg    <= '0;
            rhs_reg   <= '0;
            fv_reg    <= 1'b0;
            fault_reg <= 1'b0;
            thr_reg   <= 31'd1;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            rc_reg    <= rc_next;
            rhs_reg   <= rhs_next;
            fv_reg    <= fv_next;
            fault_reg <= fault_next;
            ov_reg    <= ov_next;
            if (psel && penable && pwrite && (paddr == tds_pkg::ADDR_PIVOT_THRESHOLD)) begin
                thr_reg <= pwdata[30:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        okind_reg  <= okind_next;
        oidx_reg   <= oidx_next;
        oval_reg   <= oval_next;
        ost_reg    <= ost_next;
        olast_reg  <= olast_next;
        lo_reg     <= lo_next;
        dg_reg     <= dg_next;
        up_reg     <= up_next;
        last_reg   <= last_next;
        idx_reg    <= idx_next;
        addr_a_reg <= addr_a_next;
        addr_b_reg <= addr_b_next;
        val_reg    <= val_next;
        su_reg     <= su_next;
        piv_reg    <= piv_next;
        xprev_reg  <= xprev_next;
        first_reg  <= first_next;
        st_reg     <= st_next;
        prod_reg   <= mul_a * mul_b;
    end

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind == tds_pkg::KIND_STATUS)) |-> m_last_result)
        else $error("status word without last flag");

    a_solution_ok_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind == tds_pkg::KIND_SOLUTION))
        |-> (m_status_code == tds_pkg::ST_OK) && (m_last_result == (m_row_index == '0)))
        else $error("solution word carries bad status or last flag");

    a_factor_count: assert property (@(posedge aclk) disable iff (!aresetn)
        fv_reg |-> (rc_reg != '0) && (rc_reg <= CW'(tds_pkg::MAX_ROWS)))
        else $error("factored matrix with impossible row count");

    a_rhs_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fv_reg |-> (rhs_reg <= rc_reg + 1'b1))
        else $error("right side count overran row count");

endmodule
`default_nettype wire

FILE: rtl/tds_ram.sv
`default_nettype none
module tds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/tds_div.sv
`default_nettype none
module tds_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tds_pkg::div_req_t req,
    output tds_pkg::div_rsp_t      rsp
);

    logic                              run_reg;
    logic                              done_reg;
    logic [tds_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic                              neg_reg;
    logic                              zero_reg;
    logic [tds_pkg::DVD_W-1:0]         dvd_reg;
    logic [tds_pkg::DATA_W-1:0]        dvs_reg;
    logic [tds_pkg::DATA_W:0]          rem_reg;

    logic [tds_pkg::DATA_W-1:0]        num_mag;
    logic [tds_pkg::DATA_W-1:0]        den_mag;
    logic [tds_pkg::DATA_W:0]          rem_sh;
    logic                              fits;
    logic signed [tds_pkg::DATA_W-1:0] quo;

    assign num_mag = req.num[tds_pkg::DATA_W-1] ? (~req.num + 32'd1) : req.num;
    assign den_mag = req.den[tds_pkg::DATA_W-1] ? (~req.den + 32'd1) : req.den;
    assign rem_sh  = {rem_reg[tds_pkg::DATA_W-1:0], dvd_reg[tds_pkg::DVD_W-1]};
    assign fits    = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                run_reg <= (req.den != '0);
                done_reg <= (req.den == '0);
                cnt_reg <= tds_pkg::DIV_CNT_W'(tds_pkg::DVD_W - 1);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge aclk) begin
        if (req.start) begin
            neg_reg  <= req.num[tds_pkg::DATA_W-1] ^ req.den[tds_pkg::DATA_W-1];
            zero_reg <= (req.den == '0);
            dvd_reg  <= {num_mag, {tds_pkg::FRAC_W{1'b0}}};
            dvs_reg  <= den_mag;
            rem_reg  <= '0;
        end else if (run_reg) begin
            rem_reg <= fits ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            dvd_reg <= {dvd_reg[tds_pkg::DVD_W-2:0], fits};
        end
    end

    always_comb begin
        if (zero_reg) begin
            quo = '0;
        end else if (neg_reg) begin
            if (dvd_reg > 48'h0000_8000_0000) begin
                quo = 32'sh80000000;
            end else begin
                quo = ~dvd_reg[tds_pkg::DATA_W-1:0] + 32'd1;
            end
        end else begin
            if (dvd_reg > 48'h0000_7FFF_FFFF) begin
                quo = 32'sh7FFFFFFF;
            end else begin
                quo = dvd_reg[tds_pkg::DATA_W-1:0];
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo;

endmodule
`default_nettype wire
